// File: design/ddmm_pkg.sv
`timescale 1ns / 1ps
// Differential drive mixer package: register indexes, fixed-point constants,
// divider stage record and the one-bit restoring division step.
// No dependencies.
package ddmm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TURN_COEFF     = 2'd0;
	localparam logic [1:0] REG_LEFT_REVERSED  = 2'd1;
	localparam logic [1:0] REG_RIGHT_REVERSED = 2'd2;

	localparam logic [15:0] TURN_COEFF_RESET = 16'd4096;

	// 100 percent in mixed units: 100 * 128 * 4096 = 25 << 21
	localparam logic [31:0] FULL_MAG   = 32'd52428800;
	localparam int unsigned FULL_SHIFT = 21;

	// quotient / scaled magnitude width, one divider stage per quotient bit
	localparam int unsigned QW        = 26;
	localparam int unsigned DIV_STEPS = QW;
	// low numerator bits fed in after the initial remainder
	localparam int unsigned NB_W      = 5;

	// duty = floor(t / 25), saturating at 255 once t reaches 256 * 25
	localparam int unsigned SAT_W     = 13;
	localparam logic [12:0] SAT_T     = 13'd6400;
	localparam logic [13:0] RECIP_25  = 14'd10486;
	localparam logic [7:0]  DUTY_MAX  = 8'd255;

	typedef struct packed {
		logic [31:0]     rem;
		logic [QW-1:0]   quo;
		logic [NB_W-1:0] nbits;
		logic [QW-1:0]   mag;
		logic            neg;
	} whl_div_t;

	function automatic whl_div_t div_step(whl_div_t x, logic [31:0] m);
		whl_div_t   y;
		logic [32:0] r2;
		logic [32:0] diff;
		logic        ge;
		y    = x;
		r2   = {x.rem, x.nbits[NB_W-1]};
		diff = r2 - {1'b0, m};
		ge   = (r2 >= {1'b0, m});
		y.rem   = ge ? diff[31:0] : r2[31:0];
		y.quo   = {x.quo[QW-2:0], ge};
		y.nbits = {x.nbits[NB_W-2:0], 1'b0};
		return y;
	endfunction

endpackage

// File: design/diff_drive_motor_mixer.sv
`timescale 1ns / 1ps
// Differential drive motor mixer, top level: mix, limit, divide, duty scale.
// Depends on ddmm_pkg.
//
// Usage
//  s_* : command transactions. s_tdata[15:0] linear_speed, [31:16] turn_rate,
//        both signed, 1/128 percent steps.
//  m_* : one result transaction per command, in order.
//  cfg_* : register writes (0 turn_coeff Q4.12, 1 left_reversed,
//        2 right_reversed), only while no command is in flight.
// Timing
//  32 register stages: multiply, mix, magnitude, limit check and x25,
//  26 restoring division stages (one quotient bit each, left and right
//  wheels in parallel), duty multiply, duty divide-by-25 into the output
//  register. One command per cycle sustained while m_tready is high.
// Stalls
//  Each stage holds while it and every stage after it are full and m_tready
//  is low; empty slots keep filling, so s_tready stays high while any bubble
//  remains. Nothing is dropped or repeated.
// Reset
//  arst_n clears all valid bits and restores the register defaults
//  (turn_coeff 1.0, no reversal). Payload registers are not reset.
module diff_drive_motor_mixer
	import ddmm_pkg::*;
#(
	parameter int unsigned DUTY_FULL_SCALE = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] linear_speed, [31:16] turn_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] left_duty, [8] left_pin_a, [9] left_pin_b, [17:10] right_duty,
	// [18] right_pin_a, [19] right_pin_b, [23:20] zero
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned DW  = $clog2(DUTY_FULL_SCALE + 1);
	localparam int unsigned PW  = DW + QW;
	localparam int unsigned TW  = PW - FULL_SHIFT;
	localparam int unsigned CW  = (TW > SAT_W) ? TW : SAT_W;
	localparam logic [DW-1:0] DUTY_K = DW'(DUTY_FULL_SCALE);

	// stage map (valid index): 0 mult, 1 mix, 2 abs, 3 limit/x25,
	// 4..29 divider, 30 duty multiply, 31 output
	localparam int unsigned DIV_FIRST = 4;
	localparam int unsigned ST_PROD   = DIV_FIRST + DIV_STEPS;
	localparam int unsigned NST       = ST_PROD + 2;

	// ---------------- configuration
	logic [15:0] coeff_q;
	logic        lrev_q;
	logic        rrev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= TURN_COEFF_RESET;
			lrev_q  <= 1'b0;
			rrev_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TURN_COEFF:     coeff_q <= cfg_data;
				REG_LEFT_REVERSED:  lrev_q  <= cfg_data[0];
				REG_RIGHT_REVERSED: rrev_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control
	// a stage may load when some stage from it to the output is empty, or
	// the output transaction completes
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	for (genvar g = 0; g < NST; g++) begin : g_en
		assign en[g] = m_tready | ~(&vld_q[NST-1:g]);
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---------------- stage 1: turn term w * k
	logic signed [32:0] turn_full;
	logic signed [15:0] lin_s1;
	logic signed [31:0] turn_s1;

	assign turn_full = $signed(s_tdata[31:16]) * $signed({1'b0, coeff_q});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lin_s1  <= $signed(s_tdata[15:0]);
			turn_s1 <= turn_full[31:0];
		end
	end

	// ---------------- stage 2: mix, v << 12 -/+ turn
	logic signed [33:0] vs_ext;
	logic signed [33:0] tr_ext;
	logic signed [33:0] wl_s2;
	logic signed [33:0] wr_s2;

	assign vs_ext = {{6{lin_s1[15]}}, lin_s1, 12'b0};
	assign tr_ext = {{2{turn_s1[31]}}, turn_s1};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			wl_s2 <= vs_ext - tr_ext;
			wr_s2 <= vs_ext + tr_ext;
		end
	end

	// ---------------- stage 3: magnitudes, direction from unscaled sign
	logic [33:0] abs_l;
	logic [33:0] abs_r;
	logic [31:0] ml_s3;
	logic [31:0] mr_s3;
	logic        nl_s3;
	logic        nr_s3;

	assign abs_l = wl_s2[33] ? 34'(-wl_s2) : 34'(wl_s2);
	assign abs_r = wr_s2[33] ? 34'(-wr_s2) : 34'(wr_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ml_s3 <= abs_l[31:0];
			mr_s3 <= abs_r[31:0];
			nl_s3 <= wl_s2[33];
			nr_s3 <= wr_s2[33];
		end
	end

	// ---------------- stage 4: limit check, numerator = mag * 25 << 21
	// quotient fits 26 bits, so the top 32 numerator bits start as remainder
	logic [36:0] n25_l;
	logic [36:0] n25_r;
	whl_div_t    dl_init;
	whl_div_t    dr_init;
	whl_div_t    dl_s4;
	whl_div_t    dr_s4;
	logic [31:0] m_s4;
	logic        ov_s4;

	assign n25_l = ({5'b0, ml_s3} << 4) + ({5'b0, ml_s3} << 3) + {5'b0, ml_s3};
	assign n25_r = ({5'b0, mr_s3} << 4) + ({5'b0, mr_s3} << 3) + {5'b0, mr_s3};

	always_comb begin
		dl_init.rem   = n25_l[36:NB_W];
		dl_init.quo   = '0;
		dl_init.nbits = n25_l[NB_W-1:0];
		dl_init.mag   = ml_s3[QW-1:0];
		dl_init.neg   = nl_s3;
		dr_init.rem   = n25_r[36:NB_W];
		dr_init.quo   = '0;
		dr_init.nbits = n25_r[NB_W-1:0];
		dr_init.mag   = mr_s3[QW-1:0];
		dr_init.neg   = nr_s3;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dl_s4 <= dl_init;
			dr_s4 <= dr_init;
			m_s4  <= (ml_s3 > mr_s3) ? ml_s3 : mr_s3;
			ov_s4 <= (ml_s3 > FULL_MAG) | (mr_s3 > FULL_MAG);
		end
	end

	// ---------------- stages 5..30: restoring division, one bit a stage
	whl_div_t    dl_s [DIV_STEPS];
	whl_div_t    dr_s [DIV_STEPS];
	logic [31:0] dm_s [DIV_STEPS];
	logic        dov_s[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en[DIV_FIRST]) begin
			dl_s[0]  <= div_step(dl_s4, m_s4);
			dr_s[0]  <= div_step(dr_s4, m_s4);
			dm_s[0]  <= m_s4;
			dov_s[0] <= ov_s4;
		end
	end

	for (genvar i = 1; i < DIV_STEPS; i++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[DIV_FIRST+i]) begin
				dl_s[i]  <= div_step(dl_s[i-1], dm_s[i-1]);
				dr_s[i]  <= div_step(dr_s[i-1], dm_s[i-1]);
				dm_s[i]  <= dm_s[i-1];
				dov_s[i] <= dov_s[i-1];
			end
		end
	end

	// ---------------- stage 31: duty scale multiply
	logic [QW-1:0] ql;
	logic [QW-1:0] qr;
	logic [PW-1:0] pl_s31;
	logic [PW-1:0] pr_s31;
	logic          nl_s31;
	logic          nr_s31;

	assign ql = dov_s[DIV_STEPS-1] ? dl_s[DIV_STEPS-1].quo : dl_s[DIV_STEPS-1].mag;
	assign qr = dov_s[DIV_STEPS-1] ? dr_s[DIV_STEPS-1].quo : dr_s[DIV_STEPS-1].mag;

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			pl_s31 <= PW'(DUTY_K) * PW'(ql);
			pr_s31 <= PW'(DUTY_K) * PW'(qr);
			nl_s31 <= dl_s[DIV_STEPS-1].neg;
			nr_s31 <= dr_s[DIV_STEPS-1].neg;
		end
	end

	// ---------------- stage 32: / FULL = >> 21 then / 25, saturating
	logic [CW-1:0] tl;
	logic [CW-1:0] tr;
	logic [26:0]   rl;
	logic [26:0]   rr;
	logic [7:0]    dutyl;
	logic [7:0]    dutyr;
	logic [7:0]    lduty_s32;
	logic [7:0]    rduty_s32;
	logic          lpa_s32;
	logic          rpa_s32;

	assign tl = CW'(pl_s31[PW-1:FULL_SHIFT]);
	assign tr = CW'(pr_s31[PW-1:FULL_SHIFT]);
	assign rl = {14'b0, tl[SAT_W-1:0]} * {13'b0, RECIP_25};
	assign rr = {14'b0, tr[SAT_W-1:0]} * {13'b0, RECIP_25};
	assign dutyl = (tl >= CW'(SAT_T)) ? DUTY_MAX : rl[25:18];
	assign dutyr = (tr >= CW'(SAT_T)) ? DUTY_MAX : rr[25:18];

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			lduty_s32 <= dutyl;
			rduty_s32 <= dutyr;
			// zero counts as forward; reversal swaps
			lpa_s32   <= ~nl_s31 ^ lrev_q;
			rpa_s32   <= ~nr_s31 ^ rrev_q;
		end
	end

	assign m_tdata = {4'b0, ~rpa_s32, rpa_s32, rduty_s32, ~lpa_s32, lpa_s32, lduty_s32};

endmodule
